// ===== rtl/core/okm_pkg.sv =====
// Package for the octree Morton key unit: widths, mode codes, payload
// structs and the elaboration-time level table builder.
// No dependencies.
`default_nettype none

package okm_pkg;

  localparam int KEY_W        = 64;
  localparam int CHILD_W      = 3;
  localparam int AXIS_W       = 2;
  localparam int LEVEL_W      = 5;
  localparam int MSB_W        = 7;
  localparam int MSB_MAX      = 64;
  localparam int DIMS_DEF     = 3;
  localparam int KEY_BITS_DEF = 64;

  typedef enum logic [1:0] {
    MODE_LEVEL   = 2'd0,
    MODE_PARENT  = 2'd1,
    MODE_CHILD   = 2'd2,
    MODE_SIBLING = 2'd3
  } okm_mode_t;

  typedef struct packed {
    okm_mode_t            mode;
    logic [KEY_W-1:0]     key;
    logic [CHILD_W-1:0]   child_index;
    logic [AXIS_W-1:0]    axis;
    logic                 dir_up;
  } okm_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_out;
    logic [LEVEL_W-1:0] level_out;
    logic               invalid;
  } okm_rsp_t;

  // Level as a function of the top set bit position: position / dims.
  typedef logic [MSB_MAX:0][MSB_W-1:0] okm_lvl_tbl_t;

  // Built by counting so that no division by an argument is needed.
  function automatic okm_lvl_tbl_t make_level_table(int dims);
    okm_lvl_tbl_t tbl;
    int           quo;
    int           rem;
    quo = 0;
    rem = 0;
    for (int i = 0; i <= MSB_MAX; i++) begin
      tbl[i] = MSB_W'(quo);
      rem++;
      if (rem == dims) begin
        rem = 0;
        quo++;
      end
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/okm_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
// Depends on okm_pkg for the payload structs.
`default_nettype none

interface okm_req_if
  import okm_pkg::*;
();
  logic     valid;
  logic     ready;
  okm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface okm_rsp_if
  import okm_pkg::*;
();
  logic     valid;
  logic     ready;
  okm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/okm_top_bit.sv =====
// Leading-one detector: position of the highest set bit, counted from 1,
// or 0 for a zero word. Depends on okm_pkg for widths.
`default_nettype none

module okm_top_bit
  import okm_pkg::*;
(
  input  logic [KEY_W-1:0] value,
  output logic [MSB_W-1:0] pos
);

  always_comb begin
    pos = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (value[i]) begin
        pos = MSB_W'(i + 1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/octree_morton_key_unit.sv =====
// Octree Morton key unit: level, parent, child and face-neighbour queries on
// sentinel-topped cell keys, one transaction per clock cycle while the
// response side takes results. Each query passes four register stages
// (top-bit detect, level lookup, neighbour candidate bits, carry/borrow
// resolve into the output register); a stall holds each occupied stage
// whose downstream stages are all full, while empty stages upstream still
// fill.
// Depends on okm_pkg, okm_if and okm_top_bit.
`default_nettype none

module octree_morton_key_unit
  import okm_pkg::*;
#(
  parameter int DIMS     = DIMS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  okm_req_if.sink   req,
  okm_rsp_if.source rsp
);

  localparam logic [KEY_W-1:0] KeyMask    = (KEY_W'(1) << KEY_BITS) - KEY_W'(1);
  localparam logic [KEY_W-1:0] DigitMask  = (KEY_W'(1) << DIMS) - KEY_W'(1);
  localparam logic [MSB_W-1:0] ChildLimit = MSB_W'(KEY_BITS - DIMS);
  localparam okm_lvl_tbl_t     LevelTable = make_level_table(DIMS);
  localparam logic [MSB_W-1:0] LevelSat   = MSB_W'((1 << LEVEL_W) - 1);

  // Stage enables.
  logic s1_en, s2_en, s3_en, s4_en;

  // Stage 1: masked key and top bit position.
  logic               s1_valid;
  okm_mode_t          s1_mode;
  logic [KEY_W-1:0]   s1_key;
  logic [CHILD_W-1:0] s1_child;
  logic [AXIS_W-1:0]  s1_axis;
  logic               s1_up;
  logic [MSB_W-1:0]   s1_msb;

  // Stage 2: level and child overflow check.
  logic               s2_valid;
  okm_mode_t          s2_mode;
  logic [KEY_W-1:0]   s2_key;
  logic [CHILD_W-1:0] s2_child;
  logic [AXIS_W-1:0]  s2_axis;
  logic               s2_up;
  logic [MSB_W-1:0]   s2_lvl;
  logic               s2_child_ok;

  // Stage 3: plain results and neighbour candidates.
  logic               s3_valid;
  okm_mode_t          s3_mode;
  logic [KEY_W-1:0]   s3_key;
  logic [KEY_W-1:0]   s3_base;
  logic               s3_base_bad;
  logic [KEY_W-1:0]   s3_amask;
  logic [KEY_W-1:0]   s3_cand;
  logic [LEVEL_W-1:0] s3_level;

  // Stage 4: output register.
  logic               s4_valid;
  okm_rsp_t           s4_rsp;

  logic [KEY_W-1:0]   in_key;
  logic [MSB_W-1:0]   msb_pos;
  logic [KEY_W-1:0]   amask_next;
  logic [KEY_W-1:0]   cand_next;
  logic [KEY_W-1:0]   base_next;
  logic               base_bad_next;
  logic [KEY_W-1:0]   flip;
  okm_rsp_t           rsp_next;

  assign s4_en = !s4_valid || rsp.ready;
  assign s3_en = !s3_valid || s4_en;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;

  assign req.ready = s1_en;
  assign rsp.valid = s4_valid;
  assign rsp.data  = s4_rsp;

  assign in_key = req.data.key & KeyMask;

  okm_top_bit u_top_bit (
    .value (in_key),
    .pos   (msb_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= req.valid;
      if (s2_en) s2_valid <= s1_valid;
      if (s3_en) s3_valid <= s2_valid;
      if (s4_en) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_mode  <= req.data.mode;
      s1_key   <= in_key;
      s1_child <= req.data.child_index;
      s1_axis  <= req.data.axis;
      s1_up    <= req.data.dir_up;
      s1_msb   <= msb_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_mode     <= s1_mode;
      s2_key      <= s1_key;
      s2_child    <= s1_child;
      s2_axis     <= s1_axis;
      s2_up       <= s1_up;
      s2_lvl      <= LevelTable[s1_msb];
      s2_child_ok <= s1_msb < ChildLimit;
    end
  end

  // A bit takes part in the walk when it belongs to the chosen axis and to
  // one of the cell's own digits. An axis at or above DIMS matches no bit.
  for (genvar p = 0; p < KEY_W; p++) begin : g_bit
    localparam int Dig = p / DIMS;
    localparam int Ax  = p % DIMS;
    assign amask_next[p] = (s2_axis == AXIS_W'(Ax)) && (MSB_W'(Dig) < s2_lvl);
    assign cand_next[p]  = amask_next[p] && (s2_key[p] != s2_up);
  end

  always_comb begin
    base_next     = '0;
    base_bad_next = 1'b0;
    unique case (s2_mode)
      MODE_LEVEL: begin
        base_next = '0;
      end
      MODE_PARENT: begin
        base_next = s2_key >> DIMS;
      end
      MODE_CHILD: begin
        if (s2_child_ok) begin
          base_next = ((s2_key << DIMS) | (KEY_W'(s2_child) & DigitMask)) & KeyMask;
        end else begin
          base_bad_next = 1'b1;
        end
      end
      MODE_SIBLING: begin
        base_next = '0;
      end
      default: begin
        base_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_mode     <= s2_mode;
      s3_key      <= s2_key;
      s3_base     <= base_next;
      s3_base_bad <= base_bad_next;
      s3_amask    <= amask_next;
      s3_cand     <= cand_next;
      s3_level    <= (s2_lvl > LevelSat) ? LEVEL_W'(LevelSat) : s2_lvl[LEVEL_W-1:0];
    end
  end

  // The lowest candidate stops the carry or borrow; every axis bit up to
  // and including it is flipped.
  assign flip = s3_amask & (s3_cand ^ (s3_cand - KEY_W'(1)));

  always_comb begin
    rsp_next.level_out = s3_level;
    if (s3_mode == MODE_SIBLING) begin
      rsp_next.invalid = (s3_cand == '0);
      rsp_next.key_out = (s3_cand == '0) ? '0 : ((s3_key ^ flip) & KeyMask);
    end else begin
      rsp_next.invalid = s3_base_bad;
      rsp_next.key_out = s3_base;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero_key: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.invalid |-> rsp.data.key_out == '0)
    else $error("invalid result carries a nonzero key");

  a_level_mode_clean: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_mode == MODE_LEVEL |-> s3_base == '0 && !s3_base_bad)
    else $error("level query produced a key or an error");

  a_cand_on_axis: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_cand & ~s3_amask) == '0)
    else $error("neighbour candidate outside the axis digits");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_en |=> s2_valid && $stable(s2_key) && $stable(s2_lvl))
    else $error("stalled stage 2 lost or changed its transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/okm_key_sb_pkg.sv =====
// Scoreboard for the octree Morton key unit testbench: predicts the answer to
// each accepted query and checks the answers that leave the block in order.
// Depends on okm_pkg for the payload structs, the mode codes and the defaults.

package okm_key_sb_pkg;
  import okm_pkg::*;

  class okm_key_scoreboard;
    okm_rsp_t    expected_answers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out the answer to one query at the default DIMS and KEY_BITS.
    function okm_rsp_t predict_answer(okm_req_t q);
      okm_rsp_t    a;
      logic [63:0] k;
      logic [63:0] walk;
      int          msb;
      int          lvl;
      int          pos;
      bit          found;
      k = q.key;
      msb = 0;
      for (int i = 0; i < KEY_W; i++) begin
        if (k[i]) msb = i + 1;
      end
      lvl = msb / DIMS_DEF;
      a.key_out = '0;
      a.level_out = (lvl > 31) ? LEVEL_W'(31) : LEVEL_W'(lvl);
      a.invalid = 1'b0;
      case (q.mode)
        MODE_PARENT: begin
          a.key_out = k >> DIMS_DEF;
        end
        MODE_CHILD: begin
          if (msb < KEY_BITS_DEF - DIMS_DEF) begin
            a.key_out = (k << DIMS_DEF) | KEY_W'(q.child_index);
          end else begin
            a.invalid = 1'b1;
          end
        end
        MODE_SIBLING: begin
          // The carry or borrow may only ripple through the cell's own digits.
          a.invalid = 1'b1;
          found = 1'b0;
          walk = k;
          if (int'(q.axis) < DIMS_DEF) begin
            for (int d = 0; d < lvl; d++) begin
              pos = int'(q.axis) + DIMS_DEF * d;
              if (!found) begin
                if (k[pos] == q.dir_up) begin
                  walk[pos] = ~walk[pos];
                end else begin
                  a.key_out = walk;
                  a.key_out[pos] = ~walk[pos];
                  a.invalid = 1'b0;
                  found = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      return a;
    endfunction

    function void note_query(okm_req_t q);
      expected_answers.push_back(predict_answer(q));
    endfunction

    function void check_answer(okm_rsp_t got);
      okm_rsp_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected answer: key_out=%h level_out=%0d invalid=%0b",
                   got.key_out, got.level_out, got.invalid);
        end
        return;
      end
      want = expected_answers.pop_front();
      if (got.key_out !== want.key_out || got.level_out !== want.level_out ||
          got.invalid !== want.invalid) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("wrong answer: expected key_out=%h level_out=%0d invalid=%0b",
                   want.key_out, want.level_out, want.invalid);
          $display("              actual   key_out=%h level_out=%0d invalid=%0b",
                   got.key_out, got.level_out, got.invalid);
        end
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for octree_morton_key_unit: directed and random key
// queries with random idling on both channels, checked by the scoreboard.
// Depends on okm_pkg, okm_if, okm_key_sb_pkg and the unit's RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import okm_pkg::*;
  import okm_key_sb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk;
  logic rst;
  bit   idling;
  int   stall_left;
  int   cycles;

  okm_req_if req_ch ();
  okm_rsp_if rsp_ch ();

  okm_key_scoreboard sb = new();

  octree_morton_key_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    idling = 1'b1;
    stall_left = 0;
    cycles = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both channels are sampled here, at the edge where a transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_query(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_answer(rsp_ch.data);
    end
  end

  // Response-side backpressure in random bursts, only while idling is set.
  always @(negedge clk) begin
    if (rst || !idling) begin
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic okm_req_t make_query(okm_mode_t mode, logic [63:0] key,
                                          logic [2:0] ci, logic [1:0] axis,
                                          logic up);
    okm_req_t q;
    q.mode = mode;
    q.key = key;
    q.child_index = ci;
    q.axis = axis;
    q.dir_up = up;
    return q;
  endfunction

  function automatic okm_req_t random_query();
    okm_req_t    q;
    logic [63:0] key;
    int          sel;
    int          lvl;
    int          msb;
    int          run;
    sel = $urandom_range(0, 99);
    lvl = $urandom_range(0, 21);
    key = {$urandom, $urandom};
    q.mode = okm_mode_t'($urandom_range(0, 3));
    q.child_index = 3'($urandom_range(0, 7));
    q.axis = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    q.dir_up = 1'($urandom_range(0, 1));
    if (sel < 70) begin
      // Well-formed key: sentinel bit above lvl random digits.
      key = (key & ((64'd1 << (DIMS_DEF * lvl)) - 64'd1)) | (64'd1 << (DIMS_DEF * lvl));
      // Force a long carry or borrow chain along the chosen axis now and then.
      if (q.mode == MODE_SIBLING && q.axis != 2'd3 && $urandom_range(0, 2) == 0) begin
        run = $urandom_range(0, lvl);
        for (int d = 0; d < run; d++) begin
          key[int'(q.axis) + DIMS_DEF * d] = q.dir_up;
        end
      end
    end else if (sel < 85) begin
      msb = $urandom_range(1, 64);
      key = (key & ((64'd1 << (msb - 1)) - 64'd1)) | (64'd1 << (msb - 1));
    end else if (sel < 95) begin
      key = {$urandom, $urandom};
    end else begin
      case ($urandom_range(0, 3))
        0: key = 64'd0;
        1: key = 64'd1;
        2: key = '1;
        default: key = 64'd1 << 63;
      endcase
    end
    q.key = key;
    return q;
  endfunction

  task automatic send_query(okm_req_t q);
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_off(int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    okm_req_t directed[$];
    rst <= 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    directed.push_back(make_query(MODE_LEVEL, 64'd0, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_LEVEL, 64'd1, 3'd7, 2'd3, 1'b1));
    directed.push_back(make_query(MODE_LEVEL, '1, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_LEVEL, 64'd1 << 63, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_LEVEL, 64'd2, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_PARENT, 64'd0, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_PARENT, 64'd1, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_PARENT, '1, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_CHILD, 64'd0, 3'd5, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_CHILD, 64'd1, 3'd7, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_CHILD, 64'd1 << 59, 3'd3, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_CHILD, 64'd1 << 60, 3'd1, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_CHILD, '1, 3'd0, 2'd0, 1'b0));
    // Carry, borrow and leaving the domain along each axis.
    directed.push_back(make_query(MODE_SIBLING, 64'h209, 3'd0, 2'd0, 1'b1));
    directed.push_back(make_query(MODE_SIBLING, 64'h280, 3'd0, 2'd1, 1'b0));
    directed.push_back(make_query(MODE_SIBLING, 64'h64, 3'd0, 2'd2, 1'b1));
    directed.push_back(make_query(MODE_SIBLING, 64'h40, 3'd0, 2'd0, 1'b0));
    directed.push_back(make_query(MODE_SIBLING, 64'd1, 3'd0, 2'd0, 1'b1));
    directed.push_back(make_query(MODE_SIBLING, 64'd0, 3'd0, 2'd1, 1'b0));
    directed.push_back(make_query(MODE_SIBLING, 64'h209, 3'd0, 2'd3, 1'b1));
    directed.push_back(make_query(MODE_SIBLING, '1, 3'd0, 2'd2, 1'b1));
    directed.push_back(make_query(MODE_SIBLING, '1, 3'd0, 2'd2, 1'b0));
    directed.push_back(make_query(MODE_SIBLING, 64'd1 << 63, 3'd0, 2'd1, 1'b1));

    foreach (directed[i]) send_query(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idle stretches alternate with busy ones; the tail runs flat out.
      idling = (n < 500) || (n >= 800 && n < 1150);
      if (idling && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 13));
      send_query(random_query());
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
